[design/foa_rot_pkg.sv]
`timescale 1ns / 1ps

package foa_rot_pkg;

  // Fixed field widths of the request and result channels.
  localparam int SAMPLE_BITS   = 24;
  localparam int COEF_IN_BITS  = 32;
  localparam int IDX_BITS      = 4;
  localparam int NCOEF         = 9;
  localparam int LEN_REG_BITS  = 13;
  localparam int SCALE_BITS    = 25;
  localparam int SCALE_SHIFT   = 24;

  // Configuration port.
  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 25;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_CHUNK_LEN  = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_STEP_SCALE = 2'd1;
  localparam logic [LEN_REG_BITS-1:0]   CHUNK_LEN_RST  = 13'd64;
  localparam logic [SCALE_BITS-1:0]     STEP_SCALE_RST = 25'd262144;

  // Request function codes.
  localparam logic FUNC_LOAD   = 1'b0;
  localparam logic FUNC_SAMPLE = 1'b1;

  // Coefficient indexes, row-major.
  localparam logic [IDX_BITS-1:0] IDX_XX   = 4'd0;
  localparam logic [IDX_BITS-1:0] IDX_YY   = 4'd4;
  localparam logic [IDX_BITS-1:0] IDX_ZZ   = 4'd8;
  localparam logic [IDX_BITS-1:0] IDX_LAST = 4'd8;

  // Matrix row and column positions.
  localparam logic [1:0] POS_X    = 2'd0;
  localparam logic [1:0] POS_Y    = 2'd1;
  localparam logic [1:0] POS_Z    = 2'd2;
  localparam logic [1:0] POS_LAST = 2'd2;

  typedef struct packed {
    logic                           func;
    logic [IDX_BITS-1:0]            coef_index;
    logic signed [COEF_IN_BITS-1:0] coef_value;
    logic signed [SAMPLE_BITS-1:0]  w_in;
    logic signed [SAMPLE_BITS-1:0]  x_in;
    logic signed [SAMPLE_BITS-1:0]  y_in;
    logic signed [SAMPLE_BITS-1:0]  z_in;
  } in_req_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] w_out;
    logic signed [SAMPLE_BITS-1:0] x_out;
    logic signed [SAMPLE_BITS-1:0] y_out;
    logic signed [SAMPLE_BITS-1:0] z_out;
    logic                          chunk_end;
  } out_req_t;

  // Tag that travels with one coefficient through the pipeline.
  typedef struct packed {
    logic                vld;
    logic [IDX_BITS-1:0] idx;
    logic [1:0]          row;
    logic [1:0]          col;
  } coef_tag_t;

endpackage

[design/foa_rot_ram.sv]
`timescale 1ns / 1ps

module foa_rot_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 9
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one read port with registered read data.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[design/foa_rot_coef.sv]
`timescale 1ns / 1ps

module foa_rot_coef #(
  parameter int COEF_BITS = 32
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  load_we,
  input  logic [foa_rot_pkg::IDX_BITS-1:0]      load_idx,
  input  logic signed [foa_rot_pkg::COEF_IN_BITS-1:0] load_val,
  input  foa_rot_pkg::coef_tag_t                rd_tag,
  input  logic                                  chunk_start,
  input  logic [foa_rot_pkg::SCALE_BITS-1:0]    step_scale,
  output foa_rot_pkg::coef_tag_t                cur_tag,
  output logic signed [COEF_BITS-1:0]           cur_coef
);

  localparam int LW = (COEF_BITS > foa_rot_pkg::COEF_IN_BITS) ? COEF_BITS
                                                              : foa_rot_pkg::COEF_IN_BITS;
  localparam int PW = COEF_BITS + 1 + foa_rot_pkg::SCALE_BITS + 1;
  localparam int SW = PW - foa_rot_pkg::SCALE_SHIFT;
  localparam logic signed [COEF_BITS-1:0] COEF_ONE = {2'b01, {(COEF_BITS-2){1'b0}}};
  localparam logic signed [COEF_BITS-1:0] COEF_MAX = {1'b0, {(COEF_BITS-1){1'b1}}};
  localparam logic signed [COEF_BITS-1:0] COEF_MIN = {1'b1, {(COEF_BITS-1){1'b0}}};

  logic signed [LW-1:0]          load_ext;
  logic signed [COEF_BITS-1:0]   load_sat;
  logic [foa_rot_pkg::NCOEF-1:0] tgt_vld_r;
  logic [foa_rot_pkg::NCOEF-1:0] cs_vld_r;
  logic [COEF_BITS-1:0]          tgt_q;
  logic [2*COEF_BITS-1:0]        cs_q;

  foa_rot_pkg::coef_tag_t        s1_tag_r;
  logic                          s1_tgt_vld_r;
  logic                          s1_cs_vld_r;
  logic                          s1_diag_r;
  logic signed [COEF_BITS-1:0]   s1_tgt;
  logic signed [COEF_BITS-1:0]   s1_cur;
  logic signed [COEF_BITS-1:0]   s1_stp;
  logic signed [COEF_BITS:0]     s1_diff;
  logic signed [foa_rot_pkg::SCALE_BITS:0] scale_s;

  foa_rot_pkg::coef_tag_t        s2_tag_r;
  logic signed [PW-1:0]          s2_prod_r;
  logic signed [COEF_BITS-1:0]   s2_cur_r;
  logic signed [COEF_BITS-1:0]   s2_stp_r;
  logic signed [SW-1:0]          s2_shr;
  logic signed [COEF_BITS-1:0]   s2_new_stp;
  logic signed [COEF_BITS-1:0]   s2_stp_sel;
  logic signed [COEF_BITS:0]     s2_sum;
  logic signed [COEF_BITS-1:0]   s2_cur_new;

  foa_rot_pkg::coef_tag_t        s3_tag_r;
  logic signed [COEF_BITS-1:0]   s3_cur_r;
  logic signed [COEF_BITS-1:0]   s3_stp_r;

  // Saturate the loaded target to the coefficient width.
  always_comb begin
    load_ext = LW'(load_val);
    if (load_ext[LW-1:COEF_BITS-1] == {(LW-COEF_BITS+1){load_ext[LW-1]}}) begin
      load_sat = load_ext[COEF_BITS-1:0];
    end else begin
      load_sat = load_ext[LW-1] ? COEF_MIN : COEF_MAX;
    end
  end

  // Target matrix store, written by load requests.
  foa_rot_ram #(
    .WIDTH(COEF_BITS),
    .DEPTH(foa_rot_pkg::NCOEF)
  ) u_tgt_ram (
    .clk  (clk),
    .we   (load_we),
    .waddr(load_idx),
    .wdata(load_sat),
    .raddr(rd_tag.idx),
    .rdata(tgt_q)
  );

  // Current coefficient and step store, read-modify-write per sample.
  foa_rot_ram #(
    .WIDTH(2 * COEF_BITS),
    .DEPTH(foa_rot_pkg::NCOEF)
  ) u_cs_ram (
    .clk  (clk),
    .we   (s3_tag_r.vld),
    .waddr(s3_tag_r.idx),
    .wdata({s3_cur_r, s3_stp_r}),
    .raddr(rd_tag.idx),
    .rdata(cs_q)
  );

  // Entry valid bits: an unwritten entry reads as its reset value.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tgt_vld_r <= '0;
      cs_vld_r  <= '0;
    end else begin
      if (load_we) begin
        tgt_vld_r[load_idx] <= 1'b1;
      end
      if (s3_tag_r.vld) begin
        cs_vld_r[s3_tag_r.idx] <= 1'b1;
      end
    end
  end

  // Read stage: note the entry state alongside the memory read.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_tag_r.vld <= 1'b0;
    end else begin
      s1_tag_r <= rd_tag;
    end
    s1_tgt_vld_r <= tgt_vld_r[rd_tag.idx];
    s1_cs_vld_r  <= cs_vld_r[rd_tag.idx];
    s1_diag_r    <= (rd_tag.idx inside {foa_rot_pkg::IDX_XX, foa_rot_pkg::IDX_YY,
                                        foa_rot_pkg::IDX_ZZ});
  end

  // Resolve reset values and form the difference to the target.
  always_comb begin
    if (s1_tgt_vld_r) begin
      s1_tgt = tgt_q;
    end else begin
      s1_tgt = s1_diag_r ? COEF_ONE : '0;
    end
    if (s1_cs_vld_r) begin
      s1_cur = cs_q[2*COEF_BITS-1:COEF_BITS];
      s1_stp = cs_q[COEF_BITS-1:0];
    end else begin
      s1_cur = s1_diag_r ? COEF_ONE : '0;
      s1_stp = '0;
    end
    s1_diff = (COEF_BITS+1)'(s1_tgt) - (COEF_BITS+1)'(s1_cur);
    scale_s = {1'b0, step_scale};
  end

  // Step multiplier stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_tag_r.vld <= 1'b0;
    end else begin
      s2_tag_r <= s1_tag_r;
    end
    s2_prod_r <= s1_diff * scale_s;
    s2_cur_r  <= s1_cur;
    s2_stp_r  <= s1_stp;
  end

  // New step at a chunk start, then advance the coefficient by its step.
  always_comb begin
    s2_shr = s2_prod_r[PW-1:foa_rot_pkg::SCALE_SHIFT];
    if (s2_shr[SW-1:COEF_BITS-1] == {(SW-COEF_BITS+1){s2_shr[SW-1]}}) begin
      s2_new_stp = s2_shr[COEF_BITS-1:0];
    end else begin
      s2_new_stp = s2_shr[SW-1] ? COEF_MIN : COEF_MAX;
    end
    s2_stp_sel = chunk_start ? s2_new_stp : s2_stp_r;
    s2_sum = (COEF_BITS+1)'(s2_cur_r) + (COEF_BITS+1)'(s2_stp_sel);
    if (s2_sum[COEF_BITS] == s2_sum[COEF_BITS-1]) begin
      s2_cur_new = s2_sum[COEF_BITS-1:0];
    end else begin
      s2_cur_new = s2_sum[COEF_BITS] ? COEF_MIN : COEF_MAX;
    end
  end

  // Write-back stage; the updated coefficient also feeds the matrix product.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_tag_r.vld <= 1'b0;
    end else begin
      s3_tag_r <= s2_tag_r;
    end
    s3_cur_r <= s2_cur_new;
    s3_stp_r <= s2_stp_sel;
  end

  assign cur_tag  = s3_tag_r;
  assign cur_coef = s3_cur_r;

endmodule

[design/foa_rot_mac.sv]
`timescale 1ns / 1ps

module foa_rot_mac #(
  parameter int COEF_BITS = 32
) (
  input  logic                                         clk,
  input  logic                                         rst_n,
  input  foa_rot_pkg::coef_tag_t                       cur_tag,
  input  logic signed [COEF_BITS-1:0]                  cur_coef,
  input  logic signed [foa_rot_pkg::SAMPLE_BITS-1:0]   x_smp,
  input  logic signed [foa_rot_pkg::SAMPLE_BITS-1:0]   y_smp,
  input  logic signed [foa_rot_pkg::SAMPLE_BITS-1:0]   z_smp,
  output logic signed [foa_rot_pkg::SAMPLE_BITS-1:0]   x_res,
  output logic signed [foa_rot_pkg::SAMPLE_BITS-1:0]   y_res,
  output logic signed [foa_rot_pkg::SAMPLE_BITS-1:0]   z_res,
  output logic                                         done
);

  localparam int SB = foa_rot_pkg::SAMPLE_BITS;
  localparam int MW = COEF_BITS + SB;
  localparam int AW = MW + 2;
  localparam int RW = AW - (COEF_BITS - 2);
  localparam logic signed [SB-1:0] SMP_MAX = {1'b0, {(SB-1){1'b1}}};
  localparam logic signed [SB-1:0] SMP_MIN = {1'b1, {(SB-1){1'b0}}};

  logic signed [SB-1:0]   smp_sel;
  foa_rot_pkg::coef_tag_t m_tag_r;
  logic signed [MW-1:0]   m_prod_r;
  foa_rot_pkg::coef_tag_t a_tag_r;
  logic signed [AW-1:0]   acc_r;
  logic signed [AW-1:0]   acc_nxt;
  logic signed [RW-1:0]   acc_shr;
  logic signed [SB-1:0]   row_sat;
  logic                   done_r;
  logic signed [SB-1:0]   x_res_r;
  logic signed [SB-1:0]   y_res_r;
  logic signed [SB-1:0]   z_res_r;

  // Pick the input channel that matches the coefficient's column.
  always_comb begin
    case (cur_tag.col)
      foa_rot_pkg::POS_X: smp_sel = x_smp;
      foa_rot_pkg::POS_Y: smp_sel = y_smp;
      foa_rot_pkg::POS_Z: smp_sel = z_smp;
      default:            smp_sel = '0;
    endcase
  end

  // Product stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_tag_r.vld <= 1'b0;
    end else begin
      m_tag_r <= cur_tag;
    end
    m_prod_r <= cur_coef * smp_sel;
  end

  // Row accumulator, restarted at the first column of each row.
  always_comb begin
    acc_nxt = ((m_tag_r.col == foa_rot_pkg::POS_X) ? AW'(0) : acc_r) + AW'(m_prod_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_tag_r.vld <= 1'b0;
    end else begin
      a_tag_r <= m_tag_r;
    end
    if (m_tag_r.vld) begin
      acc_r <= acc_nxt;
    end
  end

  // Scale the row sum back to the sample format and saturate.
  always_comb begin
    acc_shr = acc_r[AW-1:COEF_BITS-2];
    if (acc_shr[RW-1:SB-1] == {(RW-SB+1){acc_shr[RW-1]}}) begin
      row_sat = acc_shr[SB-1:0];
    end else begin
      row_sat = acc_shr[RW-1] ? SMP_MIN : SMP_MAX;
    end
  end

  // Row results; done marks the completion of the last row.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r <= 1'b0;
    end else begin
      done_r <= a_tag_r.vld && (a_tag_r.col == foa_rot_pkg::POS_LAST) &&
                (a_tag_r.row == foa_rot_pkg::POS_LAST);
    end
    if (a_tag_r.vld && (a_tag_r.col == foa_rot_pkg::POS_LAST)) begin
      case (a_tag_r.row)
        foa_rot_pkg::POS_X: x_res_r <= row_sat;
        foa_rot_pkg::POS_Y: y_res_r <= row_sat;
        foa_rot_pkg::POS_Z: z_res_r <= row_sat;
        default: ;
      endcase
    end
  end

  assign x_res = x_res_r;
  assign y_res = y_res_r;
  assign z_res = z_res_r;
  assign done  = done_r;

endmodule

[design/foa_rotator_interpolated.sv]
`timescale 1ns / 1ps

// First-order ambisonic rotator with a linearly gliding 3x3 matrix. A load
// request (func 0) writes one target coefficient. For a sample request
// (func 1), the nine coefficients stream one per cycle out of a coefficient
// memory with one read and one write port, each passing through a step
// multiplier and an update stage to write-back, and the updated values
// feed a matrix multiplier that forms the result. One result is held in
// an output register, so a new request can be taken while it waits.
// Memory contents come out of reset as the identity matrix with zero
// steps without any clearing pass. Configuration may be written only
// while no sample is being processed.
module foa_rotator_interpolated #(
  parameter int COEF_BITS = 32,
  parameter int MAX_CHUNK = 4096
) (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  logic                                      in_valid,
  output logic                                      in_stall,
  input  foa_rot_pkg::in_req_t                      in_data,
  output logic                                      out_valid,
  input  logic                                      out_stall,
  output foa_rot_pkg::out_req_t                     out_data,
  input  logic                                      cfg_we,
  input  logic [foa_rot_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
  input  logic [foa_rot_pkg::CFG_DATA_BITS-1:0]     cfg_data
);

  localparam int SB       = foa_rot_pkg::SAMPLE_BITS;
  localparam int CNT_BITS = (MAX_CHUNK > 1) ? $clog2(MAX_CHUNK) : 1;
  localparam int LEN_BITS = (CNT_BITS + 1 > foa_rot_pkg::LEN_REG_BITS) ? CNT_BITS + 1
                                                                      : foa_rot_pkg::LEN_REG_BITS;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_ISSUE = 4'b0010,
    ST_WAIT  = 4'b0100,
    ST_OUT   = 4'b1000
  } state_t;

  state_t                                    state_r;
  state_t                                    state_nxt;
  logic [foa_rot_pkg::LEN_REG_BITS-1:0]      chunk_len_r;
  logic [foa_rot_pkg::SCALE_BITS-1:0]        step_scale_r;
  logic [CNT_BITS-1:0]                       cnt_r;
  logic [foa_rot_pkg::IDX_BITS-1:0]          idx_r;
  logic [1:0]                                row_r;
  logic [1:0]                                col_r;
  logic signed [SB-1:0]                      w_r;
  logic signed [SB-1:0]                      x_r;
  logic signed [SB-1:0]                      y_r;
  logic signed [SB-1:0]                      z_r;
  logic                                      out_valid_r;
  foa_rot_pkg::out_req_t                     out_data_r;

  logic                                      in_accept;
  logic                                      load_we;
  logic                                      smp_start;
  logic                                      slot_free;
  logic                                      out_load;
  logic                                      chunk_start;
  logic                                      chunk_end;
  logic [LEN_BITS-1:0]                       len_ext;
  logic [LEN_BITS-1:0]                       len_eff;
  logic [LEN_BITS-1:0]                       cnt_inc;
  foa_rot_pkg::coef_tag_t                    rd_tag;
  foa_rot_pkg::coef_tag_t                    cur_tag;
  logic signed [COEF_BITS-1:0]               cur_coef;
  logic signed [SB-1:0]                      x_res;
  logic signed [SB-1:0]                      y_res;
  logic signed [SB-1:0]                      z_res;
  logic                                      mac_done;

  // Request handshake and decode.
  assign in_stall  = (state_r != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign load_we   = in_accept && (in_data.func == foa_rot_pkg::FUNC_LOAD) &&
                     (in_data.coef_index < foa_rot_pkg::IDX_BITS'(foa_rot_pkg::NCOEF));
  assign smp_start = in_accept && (in_data.func == foa_rot_pkg::FUNC_SAMPLE);

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chunk_len_r  <= foa_rot_pkg::CHUNK_LEN_RST;
      step_scale_r <= foa_rot_pkg::STEP_SCALE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        foa_rot_pkg::CFG_CHUNK_LEN:  chunk_len_r  <= cfg_data[foa_rot_pkg::LEN_REG_BITS-1:0];
        foa_rot_pkg::CFG_STEP_SCALE: step_scale_r <= cfg_data[foa_rot_pkg::SCALE_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Effective chunk length and end-of-chunk detection.
  always_comb begin
    len_ext = LEN_BITS'(chunk_len_r);
    if (len_ext == '0) begin
      len_eff = LEN_BITS'(1);
    end else if (len_ext > LEN_BITS'(MAX_CHUNK)) begin
      len_eff = LEN_BITS'(MAX_CHUNK);
    end else begin
      len_eff = len_ext;
    end
    cnt_inc   = LEN_BITS'(cnt_r) + LEN_BITS'(1);
    chunk_end = (cnt_inc >= len_eff);
  end

  assign chunk_start = (cnt_r == '0);
  assign slot_free   = !out_valid_r || !out_stall;
  assign out_load    = slot_free && (((state_r == ST_WAIT) && mac_done) ||
                                     (state_r == ST_OUT));

  // Sequencer state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (smp_start) begin
          state_nxt = ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        if (idx_r == foa_rot_pkg::IDX_LAST) begin
          state_nxt = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (mac_done) begin
          state_nxt = slot_free ? ST_IDLE : ST_OUT;
        end
      end
      ST_OUT: begin
        if (slot_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Coefficient walk, row-major, one memory read per cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
      row_r <= foa_rot_pkg::POS_X;
      col_r <= foa_rot_pkg::POS_X;
    end else if (smp_start) begin
      idx_r <= '0;
      row_r <= foa_rot_pkg::POS_X;
      col_r <= foa_rot_pkg::POS_X;
    end else if (state_r == ST_ISSUE) begin
      idx_r <= idx_r + 1'b1;
      if (col_r == foa_rot_pkg::POS_LAST) begin
        col_r <= foa_rot_pkg::POS_X;
        row_r <= row_r + 1'b1;
      end else begin
        col_r <= col_r + 1'b1;
      end
    end
  end

  always_comb begin
    rd_tag.vld = (state_r == ST_ISSUE);
    rd_tag.idx = idx_r;
    rd_tag.row = row_r;
    rd_tag.col = col_r;
  end

  // Sample holding registers for the duration of one request.
  always_ff @(posedge clk) begin
    if (smp_start) begin
      w_r <= in_data.w_in;
      x_r <= in_data.x_in;
      y_r <= in_data.y_in;
      z_r <= in_data.z_in;
    end
  end

  // Position within the current chunk, advanced when a result is released.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (out_load) begin
      cnt_r <= chunk_end ? '0 : cnt_r + 1'b1;
    end
  end

  foa_rot_coef #(
    .COEF_BITS(COEF_BITS)
  ) u_coef (
    .clk        (clk),
    .rst_n      (rst_n),
    .load_we    (load_we),
    .load_idx   (in_data.coef_index),
    .load_val   (in_data.coef_value),
    .rd_tag     (rd_tag),
    .chunk_start(chunk_start),
    .step_scale (step_scale_r),
    .cur_tag    (cur_tag),
    .cur_coef   (cur_coef)
  );

  foa_rot_mac #(
    .COEF_BITS(COEF_BITS)
  ) u_mac (
    .clk     (clk),
    .rst_n   (rst_n),
    .cur_tag (cur_tag),
    .cur_coef(cur_coef),
    .x_smp   (x_r),
    .y_smp   (y_r),
    .z_smp   (z_r),
    .x_res   (x_res),
    .y_res   (y_res),
    .z_res   (z_res),
    .done    (mac_done)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
    if (out_load) begin
      out_data_r.w_out     <= w_r;
      out_data_r.x_out     <= x_res;
      out_data_r.y_out     <= y_res;
      out_data_r.z_out     <= z_res;
      out_data_r.chunk_end <= chunk_end;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[tb/tb_foa_rotator_interpolated.sv]
`timescale 1ns / 1ps

import foa_rot_pkg::*;

// Tracks the rotator's matrix, steps and chunk position, and holds the
// results that accepted sample requests must produce, oldest first.
class foa_rotation_tracker;
  localparam int COEF_W    = 32;
  localparam int CHUNK_MAX = 4096;

  logic [LEN_REG_BITS-1:0] chunk_len_reg;
  logic [SCALE_BITS-1:0]   step_scale_reg;
  longint                  coef_now[NCOEF];
  longint                  coef_goal[NCOEF];
  longint                  coef_inc[NCOEF];
  int unsigned             chunk_pos;
  out_req_t                pending_samples[$];
  int unsigned             mismatches;

  // Register and matrix contents as they come out of reset.
  function new();
    chunk_len_reg  = CHUNK_LEN_RST;
    step_scale_reg = STEP_SCALE_RST;
    for (int i = 0; i < NCOEF; i++) begin
      coef_now[i]  = (i == IDX_XX || i == IDX_YY || i == IDX_ZZ) ? (64'sd1 <<< (COEF_W - 2))
                                                                 : 64'sd0;
      coef_goal[i] = coef_now[i];
      coef_inc[i]  = 0;
    end
    chunk_pos   = 0;
    mismatches  = 0;
  endfunction

  static function longint clip(longint v, int w);
    longint hi;
    hi = (64'sd1 <<< (w - 1)) - 1;
    if (v > hi) return hi;
    if (v < -hi - 1) return -hi - 1;
    return v;
  endfunction

  // Writes to unknown register indexes leave everything as it is.
  function void set_register(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
    if (idx == CFG_CHUNK_LEN) begin
      chunk_len_reg = data[LEN_REG_BITS-1:0];
    end else if (idx == CFG_STEP_SCALE) begin
      step_scale_reg = data[SCALE_BITS-1:0];
    end
  endfunction

  function void accept_request(in_req_t r);
    int unsigned len;
    longint      chan[3];
    longint      acc;
    longint      rot[3];
    out_req_t    want;
    // A load only moves the target; out-of-range indexes are dropped.
    if (r.func == FUNC_LOAD) begin
      if (r.coef_index <= IDX_LAST) begin
        coef_goal[r.coef_index] = clip(longint'(r.coef_value), COEF_W);
      end
      return;
    end
    len = 32'(chunk_len_reg);
    if (len == 0) len = 1;
    if (len > CHUNK_MAX) len = CHUNK_MAX;
    // New steps are worked out only at the first sample of a chunk.
    if (chunk_pos == 0) begin
      for (int i = 0; i < NCOEF; i++) begin
        acc = (coef_goal[i] - coef_now[i]) * longint'(step_scale_reg);
        coef_inc[i] = clip(acc >>> SCALE_SHIFT, COEF_W);
      end
    end
    for (int i = 0; i < NCOEF; i++) begin
      coef_now[i] = clip(coef_now[i] + coef_inc[i], COEF_W);
    end
    // Apply the updated matrix to X, Y and Z.
    chan[0] = longint'(r.x_in);
    chan[1] = longint'(r.y_in);
    chan[2] = longint'(r.z_in);
    for (int row = 0; row < 3; row++) begin
      acc = 0;
      for (int col = 0; col < 3; col++) begin
        acc += coef_now[row * 3 + col] * chan[col];
      end
      rot[row] = clip(acc >>> (COEF_W - 2), SAMPLE_BITS);
    end
    want.w_out     = r.w_in;
    want.x_out     = rot[0][SAMPLE_BITS-1:0];
    want.y_out     = rot[1][SAMPLE_BITS-1:0];
    want.z_out     = rot[2][SAMPLE_BITS-1:0];
    want.chunk_end = (chunk_pos + 1 >= len);
    chunk_pos      = want.chunk_end ? 0 : chunk_pos + 1;
    pending_samples.push_back(want);
  endfunction

  function void compare_field(string fld, logic [SAMPLE_BITS-1:0] want,
                              logic [SAMPLE_BITS-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, fld, want, got);
      mismatches++;
    end
  endfunction

  function void check_sample(out_req_t got);
    out_req_t want;
    if (pending_samples.size() == 0) begin
      $display("%0t: unexpected result, expected none, actual %h", $time, got);
      mismatches++;
      return;
    end
    want = pending_samples.pop_front();
    compare_field("w_out", want.w_out, got.w_out);
    compare_field("x_out", want.x_out, got.x_out);
    compare_field("y_out", want.y_out, got.y_out);
    compare_field("z_out", want.z_out, got.z_out);
    compare_field("chunk_end", SAMPLE_BITS'(want.chunk_end), SAMPLE_BITS'(got.chunk_end));
  endfunction
endclass

module tb_foa_rotator_interpolated;
  localparam int unsigned CYCLE_LIMIT   = 1000000;
  localparam int unsigned DRAIN_LIMIT   = 20000;
  localparam int unsigned SETTLE_CYCLES = 24;
  localparam int unsigned BATCH_ITEMS   = 180;
  localparam int          PHASES        = 11;

  localparam logic [CFG_INDEX_BITS-1:0]  CFG_SPARE_LO = 2'd2;
  localparam logic [CFG_INDEX_BITS-1:0]  CFG_SPARE_HI = 2'd3;
  localparam logic [IDX_BITS-1:0]        IDX_TOP      = '1;
  localparam logic [SAMPLE_BITS-1:0]     SMP_MAX      = 24'h7FFFFF;
  localparam logic [SAMPLE_BITS-1:0]     SMP_MIN      = 24'h800000;
  localparam logic [COEF_IN_BITS-1:0]    COEF_MAX     = 32'h7FFFFFFF;
  localparam logic [COEF_IN_BITS-1:0]    COEF_MIN     = 32'h80000000;

  logic                      clk       = 1'b0;
  logic                      rst_n     = 1'b0;
  logic                      in_valid  = 1'b0;
  logic                      in_stall;
  in_req_t                   in_data   = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  out_req_t                  out_data;
  logic                      cfg_we    = 1'b0;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [CFG_DATA_BITS-1:0]  cfg_data  = '0;

  foa_rotation_tracker tracker;
  int unsigned         cycles       = 0;
  int unsigned         sender_pct   = 0;
  int unsigned         receiver_pct = 0;

  // Chunk length and step scale for each random phase, extremes included.
  int unsigned phase_len[PHASES]   = '{3, 1, 0, 4, 8191, 16, 5, 2, 4096, 7, 64};
  int unsigned phase_scale[PHASES] = '{5592405, 16777216, 16777216, 4194304, 4096, 0,
                                       33554431, 8388608, 4096, 2396745, 262144};

  foa_rotator_interpolated uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Give up if the run hangs.
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Result side: random stalls, and a check of every accepted result.
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < receiver_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      tracker.check_sample(out_data);
    end
  end

  function automatic logic [SAMPLE_BITS-1:0] pick_sample();
    case ($urandom_range(7))
      0: return SMP_MAX;
      1: return SMP_MIN;
      default: return SAMPLE_BITS'($urandom);
    endcase
  endfunction

  // Mostly rotation-sized values within plus or minus one, some full range.
  function automatic logic [COEF_IN_BITS-1:0] pick_coef();
    logic [COEF_IN_BITS-1:0] v;
    v = $urandom;
    case ($urandom_range(9))
      0: return COEF_MAX;
      1: return COEF_MIN;
      2, 3: return v;
      default: return {v[30], v[30:0]};
    endcase
  endfunction

  // A sample request; the unused load fields carry noise.
  function automatic in_req_t sample_item();
    in_req_t r;
    r.func       = FUNC_SAMPLE;
    r.coef_index = IDX_BITS'($urandom);
    r.coef_value = $urandom;
    r.w_in       = pick_sample();
    r.x_in       = pick_sample();
    r.y_in       = pick_sample();
    r.z_in       = pick_sample();
    return r;
  endfunction

  function automatic in_req_t load_item(input logic [IDX_BITS-1:0] idx,
                                        input logic [COEF_IN_BITS-1:0] value);
    in_req_t r;
    r            = sample_item();
    r.func       = FUNC_LOAD;
    r.coef_index = idx;
    r.coef_value = value;
    return r;
  endfunction

  // Offer one request, with random idle cycles ahead of it, and hold it
  // until the block takes it.
  task automatic send_request(input in_req_t r);
    @(negedge clk);
    while ($urandom_range(99) < sender_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= r;
    do @(posedge clk); while (in_stall);
    tracker.accept_request(r);
  endtask

  task automatic stop_sending();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic write_register(input logic [CFG_INDEX_BITS-1:0] idx,
                                input logic [CFG_DATA_BITS-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    tracker.set_register(idx, data);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Wait for every expected result, then let trailing loads finish.
  task automatic drain_results();
    int unsigned waited;
    waited = 0;
    while (tracker.pending_samples.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Random traffic: mostly whole matrix reloads followed by runs of samples,
  // with some stray single loads, out-of-range ones among them.
  task automatic run_batch(input int unsigned target);
    int unsigned             sent;
    int unsigned             pick;
    logic [IDX_BITS-1:0]     idx;
    sent = 0;
    while (sent < target) begin
      pick = $urandom_range(99);
      if (pick < 55) begin
        for (int k = 0; k <= IDX_LAST; k++) begin
          send_request(load_item(IDX_BITS'(k), pick_coef()));
          sent++;
        end
      end else if (pick < 80) begin
        repeat ($urandom_range(1, 3)) begin
          idx = IDX_BITS'($urandom_range(IDX_TOP));
          send_request(load_item(idx, pick_coef()));
          if (idx <= IDX_LAST) sent++;
        end
      end
      repeat ($urandom_range(1, 24)) begin
        send_request(sample_item());
        sent++;
      end
    end
    stop_sending();
  endtask

  initial begin
    in_req_t r;
    tracker = new();
    sender_pct   = 35;
    receiver_pct = 51;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part at the reset settings: sample extremes through the
    // identity matrix, ignored loads, then a full target load in the middle
    // of a chunk, which must not move the matrix until the chunk ends.
    r = sample_item();
    r.w_in = '0;
    r.x_in = '0;
    r.y_in = '0;
    r.z_in = '0;
    send_request(r);
    r.w_in = SMP_MAX;
    r.x_in = SMP_MAX;
    r.y_in = SMP_MAX;
    r.z_in = SMP_MAX;
    send_request(r);
    r.w_in = SMP_MIN;
    r.x_in = SMP_MIN;
    r.y_in = SMP_MIN;
    r.z_in = SMP_MIN;
    send_request(r);
    send_request(load_item(IDX_TOP, COEF_MAX));
    send_request(load_item(IDX_BITS'(IDX_LAST + 1), COEF_MIN));
    for (int k = 0; k <= IDX_LAST; k++) begin
      send_request(load_item(IDX_BITS'(k), (k % 2 == 0) ? COEF_MAX : COEF_MIN));
    end
    repeat (8) send_request(sample_item());
    stop_sending();
    drain_results();

    // Random phases, each under its own register settings. Large chunk
    // lengths are followed by small ones, so a chunk is cut short.
    for (int p = 0; p < PHASES; p++) begin
      if (p < 4) begin
        sender_pct   = 35;
        receiver_pct = 51;
      end else if (p < 8) begin
        sender_pct   = 51;
        receiver_pct = 35;
      end else begin
        sender_pct   = 0;
        receiver_pct = 0;
      end
      write_register((p % 2 == 0) ? CFG_SPARE_LO : CFG_SPARE_HI, CFG_DATA_BITS'($urandom));
      write_register(CFG_CHUNK_LEN, CFG_DATA_BITS'(phase_len[p]));
      write_register(CFG_STEP_SCALE, CFG_DATA_BITS'(phase_scale[p]));
      run_batch(BATCH_ITEMS);
      drain_results();
    end

    if (tracker.pending_samples.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, tracker.pending_samples.size());
      tracker.mismatches++;
    end
    if (tracker.mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule

[foa_rotator_interpolated.f]
design/foa_rot_pkg.sv
design/foa_rot_ram.sv
design/foa_rot_coef.sv
design/foa_rot_mac.sv
design/foa_rotator_interpolated.sv
tb/tb_foa_rotator_interpolated.sv
